// ===== hw/rtl/dbd_pkg.sv =====
package dbd_pkg;

    // Table geometry
    localparam int MAX_BLOCKS = 1024;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int MEM_AW     = BLK_W + 1;

    // Field widths
    localparam int BS_W   = 16;
    localparam int CB_W   = 26;
    localparam int CRC_W  = 32;
    localparam int DATA_W = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Reflected CRC-32
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Register reset values
    localparam logic [BS_W-1:0] BLOCK_SIZE_RST  = 16'd4096;
    localparam logic [CB_W-1:0] CHUNK_BYTES_RST = 26'd4096;

    // Register index, taken from paddr[2]
    localparam logic REG_BLOCK_SIZE  = 1'b0;
    localparam logic REG_CHUNK_BYTES = 1'b1;

    // Input operation codes
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_COMMIT = 1'b1;

    // Item handed from the hash stage to the run tracker
    typedef struct packed {
        logic             commit;
        logic             blk_end;
        logic             last;
        logic             blk_valid;
        logic [BLK_W-1:0] idx;
        logic [CRC_W-1:0] crc;
    } dbd_item_t;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {{(CRC_W-DATA_W){1'b0}}, b};
        for (int i = 0; i < DATA_W; i++)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : '0);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/dbd_in_if.sv =====
interface dbd_in_if;
    import dbd_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

// ===== hw/rtl/dbd_out_if.sv =====
interface dbd_out_if;
    import dbd_pkg::*;

    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] block_index;
    logic             dirty;
    logic [CRC_W-1:0] block_crc;
    logic             run_closed;
    logic [BLK_W-1:0] run_first_block;
    logic [BLK_W-1:0] run_last_block;
    logic             chunk_end;

    modport source (output valid, output block_index, output dirty, output block_crc,
                    output run_closed, output run_first_block, output run_last_block,
                    output chunk_end, input ready);
    modport sink (input valid, input block_index, input dirty, input block_crc,
                  input run_closed, input run_first_block, input run_last_block,
                  input chunk_end, output ready);
endinterface

// ===== hw/rtl/dbd_hash_stage.sv =====
module dbd_hash_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    dbd_in_if.sink                      in_ch,
    input  logic [dbd_pkg::BS_W-1:0]    block_size,
    input  logic [dbd_pkg::CB_W-1:0]    chunk_bytes,
    output logic                        item_valid,
    output dbd_pkg::dbd_item_t          item,
    output logic [dbd_pkg::CRC_W-1:0]   prev_crc,
    input  logic                        item_take
);
    import dbd_pkg::*;

    // Input register
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [DATA_W-1:0] s1_byte_reg;

    // Pass state
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [CB_W-1:0]   offset_reg, offset_next;
    logic [BS_W-1:0]   bib_reg, bib_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [BLK_W:0]    fill_reg, fill_next;
    logic              committed_reg, committed_next;
    logic              sel_reg, sel_next;

    // Hand-off register and table read data
    logic              item_valid_reg;
    dbd_item_t         item_reg, item_next;
    logic [CRC_W-1:0]  rd_reg;

    // Hash tables: lower half and upper half, chosen by sel
    logic [CRC_W-1:0]  hash_mem [2*MAX_BLOCKS];

    logic              s2_free;
    logic              s1_go;
    logic [CRC_W-1:0]  crc_upd;
    logic [BS_W-1:0]   bs_eff;
    logic [CB_W-1:0]   cb_eff;
    logic [CB_W:0]     off_inc;
    logic [BS_W:0]     bib_inc;
    logic              last;
    logic              blk_end;
    logic              blk_valid;
    logic              mem_we;
    logic [MEM_AW-1:0] wr_addr;
    logic [MEM_AW-1:0] rd_addr;

    // Stage handshake
    assign s2_free     = !item_valid_reg || item_take;
    assign s1_go       = s1_valid_reg && s2_free;
    assign in_ch.ready = !s1_valid_reg || s1_go;

    // Byte and block-end decode
    assign crc_upd   = crc_byte(crc_reg, s1_byte_reg);
    assign bs_eff    = (block_size == '0) ? BS_W'(1) : block_size;
    assign cb_eff    = (chunk_bytes == '0) ? CB_W'(1) : chunk_bytes;
    assign off_inc   = {1'b0, offset_reg} + (CB_W+1)'(1);
    assign bib_inc   = {1'b0, bib_reg} + (BS_W+1)'(1);
    assign last      = off_inc >= {1'b0, cb_eff};
    assign blk_end   = last || (bib_inc >= {1'b0, bs_eff});
    // Entries below the fill count were cleared since the last commit
    assign blk_valid = committed_reg && ({1'b0, blk_reg} >= fill_reg);

    assign mem_we  = s1_go && (s1_op_reg == OP_DATA) && blk_end;
    assign wr_addr = {~sel_reg, blk_reg};
    assign rd_addr = {sel_reg, blk_reg};

    // Advance pass state
    always_comb
    begin
        crc_next       = crc_reg;
        offset_next    = offset_reg;
        bib_next       = bib_reg;
        blk_next       = blk_reg;
        fill_next      = fill_reg;
        committed_next = committed_reg;
        sel_next       = sel_reg;

        item_next           = '0;
        item_next.idx       = blk_reg;
        item_next.crc       = ~crc_upd;
        item_next.last      = last;
        item_next.blk_valid = blk_valid;

        if (s1_op_reg == OP_COMMIT)
        begin
            item_next.commit = 1'b1;
            committed_next   = 1'b1;
            fill_next        = '0;
            sel_next         = ~sel_reg;
            crc_next         = CRC_INIT;
            offset_next      = '0;
            bib_next         = '0;
            blk_next         = '0;
        end
        else if (blk_end)
        begin
            item_next.blk_end = 1'b1;
            crc_next          = CRC_INIT;
            bib_next          = '0;
            if ({1'b0, blk_reg} == fill_reg)
            begin
                fill_next = fill_reg + (BLK_W+1)'(1);
            end
            if (last)
            begin
                offset_next = '0;
                blk_next    = '0;
            end
            else
            begin
                offset_next = off_inc[CB_W-1:0];
                blk_next    = (blk_reg == BLK_W'(MAX_BLOCKS-1)) ? '0 : blk_reg + BLK_W'(1);
            end
        end
        else
        begin
            crc_next    = crc_upd;
            offset_next = off_inc[CB_W-1:0];
            bib_next    = bib_inc[BS_W-1:0];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_op_reg   <= in_ch.op;
            s1_byte_reg <= in_ch.data_byte;
        end
    end

    // Pass state and hand-off valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            offset_reg     <= '0;
            bib_reg        <= '0;
            blk_reg        <= '0;
            fill_reg       <= '0;
            committed_reg  <= 1'b0;
            sel_reg        <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                crc_reg       <= crc_next;
                offset_reg    <= offset_next;
                bib_reg       <= bib_next;
                blk_reg       <= blk_next;
                fill_reg      <= fill_next;
                committed_reg <= committed_next;
                sel_reg       <= sel_next;
            end
            if (s2_free)
            begin
                item_valid_reg <= s1_go;
            end
        end
    end

    // Hand-off payload
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            item_reg <= item_next;
        end
    end

    // Write the next table, read the current one
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hash_mem[wr_addr] <= ~crc_upd;
        end
        if (s1_go)
        begin
            rd_reg <= hash_mem[rd_addr];
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;
    assign prev_crc   = rd_reg;

endmodule

// ===== hw/rtl/dirty_block_detector.sv =====
// Channel   Dir  Word                                     Accepted when
// in_ch     in   op, data_byte                            valid && ready
// out_ch    out  block_index, dirty, block_crc,           valid && ready
//                run_closed, run_first_block,
//                run_last_block, chunk_end
// apb       in   block_size @0x0, chunk_bytes @0x4        psel && penable && pwrite
//
// One word per cycle sustained while the output is not stalled; a result passes the input register,
// the table read and the output register after its closing byte is accepted.
// The table RAM is read on every accepted word and written at block ends, so it never limits the rate.
// Reset needs no clearing pass: validity comes from a fill count since the last commit.
// A stalled output holds its word while the two inner stages keep filling behind it.
module dirty_block_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    dbd_in_if.sink                        in_ch,
    dbd_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbd_pkg::APB_AW-1:0]    paddr,
    input  logic [dbd_pkg::APB_DW-1:0]    pwdata,
    output logic [dbd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import dbd_pkg::*;

    // Configuration
    logic [BS_W-1:0]  block_size_reg;
    logic [CB_W-1:0]  chunk_bytes_reg;
    logic             cfg_we;

    // Hash stage hand-off
    logic             item_valid;
    dbd_item_t        item;
    logic [CRC_W-1:0] prev_crc;
    logic             item_take;
    logic             item_go;

    // Run tracking
    logic             in_run_reg, in_run_next;
    logic [BLK_W-1:0] run_begin_reg, run_begin_next;
    logic             dirty;
    logic             closed;
    logic [BLK_W-1:0] first;
    logic [BLK_W-1:0] last_blk;
    logic [BLK_W-1:0] prev_idx;

    // Output register
    logic             out_valid_reg;
    logic             out_free;
    logic [BLK_W-1:0] index_reg;
    logic             dirty_reg;
    logic [CRC_W-1:0] crc_reg;
    logic             closed_reg;
    logic [BLK_W-1:0] first_reg;
    logic [BLK_W-1:0] last_reg;
    logic             end_reg;

    // Register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg  <= BLOCK_SIZE_RST;
            chunk_bytes_reg <= CHUNK_BYTES_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_BLOCK_SIZE:  block_size_reg  <= pwdata[BS_W-1:0];
                REG_CHUNK_BYTES: chunk_bytes_reg <= pwdata[CB_W-1:0];
                default:         block_size_reg  <= block_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BLOCK_SIZE:  prdata = {{(APB_DW-BS_W){1'b0}}, block_size_reg};
            REG_CHUNK_BYTES: prdata = {{(APB_DW-CB_W){1'b0}}, chunk_bytes_reg};
            default:         prdata = '0;
        endcase
    end

    dbd_hash_stage u_hash (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .block_size  (block_size_reg),
        .chunk_bytes (chunk_bytes_reg),
        .item_valid  (item_valid),
        .item        (item),
        .prev_crc    (prev_crc),
        .item_take   (item_take)
    );

    // Only block ends need room in the output register
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign item_take = !item.blk_end || out_free;
    assign item_go   = item_valid && item_take;

    // Classify the block and close runs
    assign dirty    = !item.blk_valid || (prev_crc != item.crc);
    assign prev_idx = (item.idx == '0) ? BLK_W'(MAX_BLOCKS-1) : item.idx - BLK_W'(1);

    always_comb
    begin
        in_run_next    = in_run_reg;
        run_begin_next = run_begin_reg;
        closed         = 1'b0;
        first          = '0;
        last_blk       = '0;

        if (item.commit)
        begin
            in_run_next    = 1'b0;
            run_begin_next = '0;
        end
        else if (dirty)
        begin
            if (!in_run_reg)
            begin
                in_run_next    = 1'b1;
                run_begin_next = item.idx;
            end
            if (item.last)
            begin
                closed      = 1'b1;
                first       = in_run_reg ? run_begin_reg : item.idx;
                last_blk    = item.idx;
                in_run_next = 1'b0;
            end
        end
        else if (in_run_reg)
        begin
            closed      = 1'b1;
            first       = run_begin_reg;
            last_blk    = prev_idx;
            in_run_next = 1'b0;
        end

        // Chunk end restarts the pass
        if (!item.commit && item.last)
        begin
            run_begin_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg    <= 1'b0;
            run_begin_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_go && (item.commit || item.blk_end))
            begin
                in_run_reg    <= in_run_next;
                run_begin_reg <= run_begin_next;
            end
            if (out_free)
            begin
                out_valid_reg <= item_go && item.blk_end;
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (out_free && item_go && item.blk_end)
        begin
            index_reg  <= item.idx;
            dirty_reg  <= dirty;
            crc_reg    <= item.crc;
            closed_reg <= closed;
            first_reg  <= first;
            last_reg   <= last_blk;
            end_reg    <= item.last;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.block_index     = index_reg;
    assign out_ch.dirty           = dirty_reg;
    assign out_ch.block_crc       = crc_reg;
    assign out_ch.run_closed      = closed_reg;
    assign out_ch.run_first_block = first_reg;
    assign out_ch.run_last_block  = last_reg;
    assign out_ch.chunk_end       = end_reg;

endmodule

// ===== hw/rtl/dbd_checker.sv =====
module dbd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [dbd_pkg::BLK_W-1:0]   block_index,
    input  logic                        dirty,
    input  logic [dbd_pkg::CRC_W-1:0]   block_crc,
    input  logic                        run_closed,
    input  logic [dbd_pkg::BLK_W-1:0]   run_first_block,
    input  logic [dbd_pkg::BLK_W-1:0]   run_last_block,
    input  logic                        chunk_end
);
    import dbd_pkg::*;

    // Hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_crc) && $stable(block_index))
        else $error("output word changed while stalled");

    // A run closed inside the chunk ends at a clean block
    a_mid_close_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_closed && !chunk_end |-> !dirty)
        else $error("run closed mid-chunk on a dirty block");

    // That run ends on the block before
    a_mid_close_prev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_closed && !chunk_end |->
            run_last_block == BLK_W'(block_index - BLK_W'(1)))
        else $error("closed run does not end on the previous block");

    // A run closed by a dirty last block ends on it
    a_end_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_closed && chunk_end && dirty |-> run_last_block == block_index)
        else $error("run closed at chunk end does not end on the last block");

    // No run bounds without a closed run
    a_no_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_closed |-> run_first_block == '0 && run_last_block == '0)
        else $error("run bounds set without a closed run");

endmodule

bind dirty_block_detector dbd_checker u_dbd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .block_index     (out_ch.block_index),
    .dirty           (out_ch.dirty),
    .block_crc       (out_ch.block_crc),
    .run_closed      (out_ch.run_closed),
    .run_first_block (out_ch.run_first_block),
    .run_last_block  (out_ch.run_last_block),
    .chunk_end       (out_ch.chunk_end)
);

// ===== bench/dbd_checker.sv =====
`timescale 1ns / 1ps

module dbd_scoreboard (
    input  logic                       clk,
    input  logic                       rst_n,
    dbd_in_if                          in_mon,
    dbd_out_if                         out_mon,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [dbd_pkg::APB_AW-1:0] paddr,
    input  logic [dbd_pkg::APB_DW-1:0] pwdata,
    output int                         errors,
    output int                         reports_due
);
    import dbd_pkg::*;

    typedef struct packed {
        logic [BLK_W-1:0] blk_idx;
        logic             dirty;
        logic [CRC_W-1:0] crc;
        logic             closed;
        logic [BLK_W-1:0] first;
        logic [BLK_W-1:0] last;
        logic             chunk_end;
    } block_report_t;

    // Register shadows
    logic [BS_W-1:0]  cfg_bs;
    logic [CB_W-1:0]  cfg_cb;

    // Pass state
    logic [CRC_W-1:0] crc_acc;
    int unsigned      chunk_pos;
    int unsigned      blk_pos;
    logic [BLK_W-1:0] blk_no;
    bit               run_open;
    logic [BLK_W-1:0] run_start;

    // Hash tables and per-block validity
    logic [CRC_W-1:0] crc_tab [2][MAX_BLOCKS];
    bit               seen_ok [MAX_BLOCKS];
    bit               tab_sel;

    block_report_t    report_q [$];
    int               err_cnt;

    // Shift one byte into the CRC, lowest bit first
    function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] c,
                                                   input logic [DATA_W-1:0] b);
        logic fb;
        for (int i = 0; i < DATA_W; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic rewind_pass();
        crc_acc   = CRC_INIT;
        chunk_pos = 0;
        blk_pos   = 0;
        blk_no    = '0;
        run_open  = 1'b0;
        run_start = '0;
    endtask

    // Advance the predicted state by one accepted word
    task automatic track_word(input logic op, input logic [DATA_W-1:0] b);
        int unsigned   bs_eff;
        int unsigned   cb_eff;
        logic [CRC_W-1:0] crc;
        logic          chunk_done;
        logic          dirt;
        block_report_t rep;

        if (op == OP_COMMIT)
        begin
            for (int k = 0; k < MAX_BLOCKS; k++)
                seen_ok[k] = 1'b1;
            tab_sel = !tab_sel;
            rewind_pass();
            return;
        end

        crc_acc    = fold_byte(crc_acc, b);
        bs_eff     = (cfg_bs == 0) ? 1 : cfg_bs;
        cb_eff     = (cfg_cb == 0) ? 1 : cfg_cb;
        chunk_done = (chunk_pos + 1 >= cb_eff);

        if (!chunk_done && blk_pos + 1 < bs_eff)
        begin
            chunk_pos++;
            blk_pos++;
            return;
        end

        // Block end: store in the next table, compare with the current one
        crc = ~crc_acc;
        crc_tab[!tab_sel][blk_no] = crc;
        dirt = !seen_ok[blk_no] || (crc_tab[tab_sel][blk_no] != crc);
        seen_ok[blk_no] = 1'b0;

        rep           = '0;
        rep.blk_idx   = blk_no;
        rep.dirty     = dirt;
        rep.crc       = crc;
        rep.chunk_end = chunk_done;

        // Close a dirty run on the first clean block or at the chunk end
        if (dirt)
        begin
            if (!run_open)
            begin
                run_open  = 1'b1;
                run_start = blk_no;
            end
            if (chunk_done)
            begin
                rep.closed = 1'b1;
                rep.first  = run_start;
                rep.last   = blk_no;
                run_open   = 1'b0;
            end
        end
        else if (run_open)
        begin
            rep.closed = 1'b1;
            rep.first  = run_start;
            rep.last   = blk_no - 1'b1;
            run_open   = 1'b0;
        end

        report_q.push_back(rep);

        if (chunk_done)
            rewind_pass();
        else
        begin
            crc_acc = CRC_INIT;
            chunk_pos++;
            blk_pos = 0;
            blk_no  = blk_no + 1'b1;
        end
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Compare one accepted result word with the oldest prediction
    task automatic check_report();
        block_report_t want;
        if (report_q.size() == 0)
        begin
            $display("%0t: result word expected none actual block %0d crc %08h",
                     $time, out_mon.block_index, out_mon.block_crc);
            err_cnt++;
            return;
        end
        want = report_q.pop_front();
        match_field("block_index", 32'(want.blk_idx), 32'(out_mon.block_index));
        match_field("dirty", 32'(want.dirty), 32'(out_mon.dirty));
        match_field("block_crc", want.crc, out_mon.block_crc);
        match_field("run_closed", 32'(want.closed), 32'(out_mon.run_closed));
        match_field("run_first_block", 32'(want.first), 32'(out_mon.run_first_block));
        match_field("run_last_block", 32'(want.last), 32'(out_mon.run_last_block));
        match_field("chunk_end", 32'(want.chunk_end), 32'(out_mon.chunk_end));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bs  = BLOCK_SIZE_RST;
            cfg_cb  = CHUNK_BYTES_RST;
            tab_sel = 1'b0;
            err_cnt = 0;
            rewind_pass();
            for (int k = 0; k < MAX_BLOCKS; k++)
            begin
                seen_ok[k]    = 1'b0;
                crc_tab[0][k] = '0;
                crc_tab[1][k] = '0;
            end
            report_q.delete();
        end
        else
        begin
            // Follow register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_BLOCK_SIZE)
                    cfg_bs = pwdata[BS_W-1:0];
                else
                    cfg_cb = pwdata[CB_W-1:0];
            end
            if (in_mon.valid && in_mon.ready)
                track_word(in_mon.op, in_mon.data_byte);
            if (out_mon.valid && out_mon.ready)
                check_report();
        end
        errors      <= err_cnt;
        reports_due <= report_q.size();
    end

endmodule

// ===== bench/dirty_block_detector_tb.sv =====
`timescale 1ns / 1ps

module dirty_block_detector_tb;
    import dbd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int IMAGE_BYTES = 4096;
    localparam int PHASES      = 12;
    localparam int FILL_BYTES  = 160;
    localparam int RUN_BLOCK   = 40;

    localparam logic [APB_AW-1:0] ADDR_BLOCK_SIZE  = {REG_BLOCK_SIZE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_CHUNK_BYTES = {REG_CHUNK_BYTES, 2'b00};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                due_count;

    // Memory image streamed pass after pass, mutated at random
    logic [DATA_W-1:0] image [IMAGE_BYTES];
    int unsigned       pass_pos;
    int unsigned       chunk_len;
    int unsigned       mut_rate;
    bit                calm;
    bit                hold_req;
    bit                hold_done;
    int                cycle_no;

    dbd_in_if  in_ch ();
    dbd_out_if out_ch ();

    dirty_block_detector u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dbd_scoreboard u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (fail_count),
        .reports_due (due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        cycle_no = 0;
        while (cycle_no < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_no++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        stall_left   = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Offer one word and hold it until accepted
    task automatic send_word(input logic op, input logic [DATA_W-1:0] b);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Drain: drop valid, wait for every result, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (due_count != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int unsigned bs, input int unsigned cb);
        settle();
        apb_write(ADDR_BLOCK_SIZE, bs);
        apb_write(ADDR_CHUNK_BYTES, cb);
        chunk_len = (cb == 0) ? 1 : cb;
    endtask

    // Send the next image byte, mutating it now and then
    task automatic put_byte();
        int unsigned slot;
        slot = pass_pos % IMAGE_BYTES;
        if (mut_rate != 0 && $urandom_range(1, mut_rate) == 1)
            image[slot] ^= 8'($urandom_range(1, 255));
        send_word(OP_DATA, image[slot]);
        pass_pos++;
        if (pass_pos >= chunk_len)
            pass_pos = 0;
    endtask

    task automatic put_value(input logic [DATA_W-1:0] b);
        image[pass_pos % IMAGE_BYTES] = b;
        put_byte();
    endtask

    task automatic put_commit();
        send_word(OP_COMMIT, 8'($urandom));
        pass_pos = 0;
    endtask

    initial
    begin
        int unsigned bs;
        int unsigned cb;
        int          n;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_DATA;
        in_ch.data_byte = '0;
        calm            = 1'b0;
        hold_req        = 1'b0;
        pass_pos        = 0;
        chunk_len       = CHUNK_BYTES_RST;
        mut_rate        = 0;
        for (int i = 0; i < IMAGE_BYTES; i++)
            image[i] = 8'($urandom);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset sizes, then a mid-pass drop to zero sizes
        put_value(8'h00);
        put_value(8'hFF);
        put_value(8'hA5);
        configure(0, 0);
        put_value(8'hFF);
        put_value(8'h00);

        // Directed: short last block
        configure(2, 5);
        put_value(8'h00);
        put_value(8'hFF);
        put_value(8'h80);
        put_value(8'h01);
        put_value(8'h7F);

        // Directed: largest block, chunk shorter than a block
        configure(16'hFFFF, 3);
        put_value(8'hFF);
        put_value(8'hFF);
        put_value(8'hFF);

        configure(3, 6);
        repeat (6) put_value(8'($urandom));

        // Fill both tables over every block index the random phases reach
        configure(1, FILL_BYTES);
        repeat (FILL_BYTES) put_byte();
        put_commit();
        // Dirty two neighboring blocks so a run closes on the next clean one
        image[RUN_BLOCK]     ^= 8'h5A;
        image[RUN_BLOCK + 1] ^= 8'hC3;
        repeat (FILL_BYTES) put_byte();
        put_commit();

        // Random phases of passes with commits, noise commits and mutations
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    bs = 16'hFFFF;
                    cb = 26'h3FF_FFFF;
                    n  = 40;
                end
                1:
                begin
                    bs = 513;
                    cb = $urandom_range(0, 40);
                    n  = 60;
                end
                2:
                begin
                    bs = 1;
                    cb = 48;
                    n  = 120;
                end
                PHASES - 2:
                begin
                    bs = 0;
                    cb = 0;
                    n  = 30;
                end
                default:
                begin
                    bs = $urandom_range(0, 10);
                    cb = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 150);
                    n  = 60;
                end
            endcase
            configure(bs, cb);
            mut_rate = 3 << (2 * $urandom_range(0, 2));
            calm     = (ph >= PHASES - 2);
            if (ph == 2)
                hold_req = 1'b1;
            for (int k = 0; k < n; k++)
            begin
                if (pass_pos == 0 && k > 0 && $urandom_range(0, 3) == 0)
                    put_commit();
                else if ($urandom_range(0, 79) == 0)
                    put_commit();
                else
                    put_byte();
            end
        end

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
